@@ rtl/core/cir_pkg.sv @@
// ----------------------------------------------------------------------------
// Contact impulse resolver package
// Shared types, codes, constants and the saturation helper of the resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int BODY_COUNT_DEF = 64;
  localparam int ONE_Q16        = 65536;
  localparam int TAN_MIN        = 6;
  localparam int DIV_STEPS      = 52;
  localparam int SQRT_STEPS     = 32;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESOLVE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_READ        = 3'd0,
    OUT_BOTH_STATIC = 3'd1,
    OUT_SEPARATING  = 3'd2,
    OUT_IMPULSE     = 3'd3,
    OUT_STATIC      = 3'd4,
    OUT_DYNAMIC     = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_FRIC   = 2'd2
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_REDUCE, ST_DISPATCH, ST_RD_A, ST_GET_A, ST_GET_B, ST_INIT,
    ST_REL, ST_DOT_M, ST_DOT_A, ST_DOT_END, ST_E_M, ST_E_A, ST_J_M, ST_J_A,
    ST_DIV, ST_J_DONE, ST_D_M, ST_D_A, ST_APA_M, ST_APA_A, ST_APB_M, ST_APB_A,
    ST_T_M, ST_T_A, ST_SQ_M, ST_SQ_A, ST_SQRT, ST_L_DONE, ST_U_DIV, ST_U_DONE,
    ST_FR_M1, ST_FR_A1, ST_FR_M2, ST_FR_A2, ST_MUS_DONE, ST_F_DIV, ST_F_DONE,
    ST_CMP_M, ST_CMP_A, ST_MUD_DONE, ST_JM_M, ST_JM_A, ST_WB_A, ST_WB_B,
    ST_EMIT_A, ST_EMIT_B
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        dfr;
    logic [15:0]        sfr;
    logic [16:0]        rest;
    logic [23:0]        inv;
    logic signed [31:0] vz;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
  } body_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] y;
    if (x > 66'sd2147483647) begin
      y = 32'sh7FFFFFFF;
    end else if (x < -66'sd2147483648) begin
      y = 32'sh80000000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

@@ rtl/core/contact_impulse_resolver.sv @@
// ----------------------------------------------------------------------------
// Contact impulse resolver
// Body table with impulse and Coulomb friction contact resolution.
// ----------------------------------------------------------------------------
// Items arrive on the s_ group, kind in s_tuser. A load transfer writes one
// body entry and returns nothing. A read transfer returns one result with
// the body's velocity. A resolve transfer returns two results, body A and
// then body B, the second with m_tlast high; m_tuser carries the outcome.
// The block takes one item at a time and holds s_tready low while it works.
// A resolve uses one shared 33x33 multiplier, a 52-step radix-2 divider
// (up to five divisions) and a 32-step square root (up to three roots),
// all run in turn by the sequencer.
// Reset returns the sequencer to idle and drops m_tvalid; the body table is
// not cleared, so a body must be loaded before it is used.
// When the receiver stalls, the finished result waits in the output
// register and the sequencer waits before its next result transfer.
// ----------------------------------------------------------------------------
module contact_impulse_resolver
  import cir_pkg::*;
#(
  parameter int BODY_COUNT = BODY_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // body_a, body_b, vec_x, vec_y, vec_z, inverse_mass, bounce,
  // grip_static, grip_dynamic, body_mode, zero fill
  input  logic [183:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // body_id, out_vx, out_vy, out_vz, zero fill
  output logic [103:0] m_tdata,
  // outcome
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam int AW = $clog2(BODY_COUNT);

  state_t state, state_next;
  kind_t  kind;
  phase_t phase;
  outcome_t outcome;
  logic [5:0] ra, rb;
  body_t ld, ent_a, ent_b, rd_data, wdata;
  body_t body_mem [BODY_COUNT];
  logic [AW-1:0] raddr, waddr;
  logic wen;

  logic signed [31:0] va [3];
  logic signed [31:0] vb [3];
  logic signed [31:0] r [3];
  logic signed [31:0] t [3];
  logic signed [31:0] u [3];
  logic signed [31:0] d [3];
  logic signed [31:0] nspd, j, f, fvel;
  logic signed [32:0] dsrc;
  logic signed [49:0] acc;
  logic [17:0] e, mus, mud;
  logic [32:0] len;
  logic [63:0] sq;
  logic fr_dyn;
  logic [1:0] k, k_wrap;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [51:0] dv;
  logic [32:0] ds, rem;
  logic [33:0] rem_sh;
  logic div_neg;
  state_t div_ret, sqrt_ret;
  logic [63:0] sv, sr, sbit, s_sum;
  logic [5:0] cnt;

  logic da, db, wa, wb;
  logic [23:0] ia, ib;
  logic [24:0] msum;
  logic [16:0] ea, eb;
  logic [15:0] sa, sb, ka, kb;
  logic signed [31:0] nk, dot_val, quot_s, jm_val;
  logic [32:0] tabs, fabs, af;
  logic ra_big, rb_big, out_free, div_last, sqrt_last, static_hit, vsel;

  assign da   = ent_a.mode[0];
  assign db   = ent_b.mode[0];
  assign wa   = da && ent_a.mode[1];
  assign wb   = db && ent_b.mode[1];
  assign ia   = da ? ent_a.inv : 24'd0;
  assign ib   = db ? ent_b.inv : 24'd0;
  assign msum = 25'(ia) + 25'(ib);
  assign ea   = da ? ent_a.rest : 17'(ONE_Q16);
  assign eb   = db ? ent_b.rest : 17'(ONE_Q16);
  assign sa   = da ? ent_a.sfr : 16'd0;
  assign sb   = db ? ent_b.sfr : 16'd0;
  assign ka   = da ? ent_a.dfr : 16'd0;
  assign kb   = db ? ent_b.dfr : 16'd0;

  assign nk = (k == 2'd0) ? ld.vx : ((k == 2'd1) ? ld.vy : ld.vz);
  assign k_wrap = (k == 2'd2) ? 2'd0 : k + 2'd1;
  assign vsel = (phase == PH_FRIC);

  assign ra_big = {26'd0, ra} >= 32'(BODY_COUNT);
  assign rb_big = {26'd0, rb} >= 32'(BODY_COUNT);
  assign out_free = !m_tvalid || m_tready;

  assign dot_val = sat32(66'(acc));
  assign quot_s  = sat32(div_neg ? -$signed({14'd0, dv}) : $signed({14'd0, dv}));
  assign jm_val  = sat32(prod >>> 12);
  assign tabs    = t[k][31] ? 33'(-(33'(t[k]))) : 33'(t[k]);
  assign fabs    = fvel[31] ? 33'(-(33'(fvel))) : 33'(fvel);
  assign af      = f[31] ? 33'(-(33'(f))) : 33'(f);
  assign static_hit = $signed({21'd0, af, 12'd0}) < prod;

  assign rem_sh    = {rem, dv[51]};
  assign s_sum     = sr + sbit;
  assign div_last  = (cnt == 6'(DIV_STEPS - 1));
  assign sqrt_last = (cnt == 6'(SQRT_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_REDUCE;
      ST_REDUCE:   if (!ra_big && !rb_big) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (kind)
          KIND_READ, KIND_RESOLVE: state_next = ST_RD_A;
          default:                 state_next = ST_IDLE;
        endcase
      end
      ST_RD_A:     state_next = ST_GET_A;
      ST_GET_A:    state_next = (kind == KIND_READ) ? ST_EMIT_A : ST_GET_B;
      ST_GET_B:    state_next = ST_INIT;
      ST_INIT:     state_next = (msum == 25'd0) ? ST_WB_A : ST_REL;
      ST_REL:      state_next = ST_DOT_M;
      ST_DOT_M:    state_next = ST_DOT_A;
      ST_DOT_A:    state_next = (k == 2'd2) ? ST_DOT_END : ST_DOT_M;
      ST_DOT_END: begin
        case (phase)
          PH_FIRST:  state_next = (dot_val >= 0) ? ST_WB_A : ST_E_M;
          PH_SECOND: state_next = ST_T_M;
          default:   state_next = ST_FR_M1;
        endcase
      end
      ST_E_M:      state_next = ST_E_A;
      ST_E_A:      state_next = ST_J_M;
      ST_J_M:      state_next = ST_J_A;
      ST_J_A:      state_next = ST_DIV;
      ST_DIV:      if (div_last) state_next = div_ret;
      ST_J_DONE:   state_next = ST_D_M;
      ST_D_M:      state_next = ST_D_A;
      ST_D_A:      state_next = (k == 2'd2) ? ST_APA_M : ST_D_M;
      ST_APA_M:    state_next = ST_APA_A;
      ST_APA_A:    state_next = ST_APB_M;
      ST_APB_M:    state_next = ST_APB_A;
      ST_APB_A: begin
        if (k != 2'd2) begin
          state_next = ST_APA_M;
        end else begin
          state_next = (phase == PH_FIRST) ? ST_REL : ST_WB_A;
        end
      end
      ST_T_M:      state_next = ST_T_A;
      ST_T_A:      state_next = ST_SQ_M;
      ST_SQ_M:     state_next = ST_SQ_A;
      ST_SQ_A:     state_next = (k == 2'd2) ? ST_SQRT : ST_T_M;
      ST_SQRT:     if (sqrt_last) state_next = sqrt_ret;
      ST_L_DONE:   state_next = (sr > 64'(TAN_MIN)) ? ST_U_DIV : ST_WB_A;
      ST_U_DIV:    state_next = ST_DIV;
      ST_U_DONE:   state_next = (k == 2'd2) ? ST_DOT_M : ST_U_DIV;
      ST_FR_M1:    state_next = ST_FR_A1;
      ST_FR_A1:    state_next = ST_FR_M2;
      ST_FR_M2:    state_next = ST_FR_A2;
      ST_FR_A2:    state_next = ST_SQRT;
      ST_MUS_DONE: state_next = ST_F_DIV;
      ST_F_DIV:    state_next = ST_DIV;
      ST_F_DONE:   state_next = ST_CMP_M;
      ST_CMP_M:    state_next = ST_CMP_A;
      ST_CMP_A:    state_next = static_hit ? ST_D_M : ST_FR_M1;
      ST_MUD_DONE: state_next = ST_JM_M;
      ST_JM_M:     state_next = ST_JM_A;
      ST_JM_A:     state_next = ST_D_M;
      ST_WB_A:     state_next = ST_WB_B;
      ST_WB_B:     state_next = ST_EMIT_A;
      ST_EMIT_A: begin
        if (out_free) state_next = (kind == KIND_READ) ? ST_IDLE : ST_EMIT_B;
      end
      ST_EMIT_B:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    raddr = (state == ST_GET_A) ? AW'(rb) : AW'(ra);
    wen   = 1'b0;
    waddr = AW'(ra);
    wdata = ld;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DISPATCH: wen = (kind == KIND_LOAD);
      ST_WB_A: begin
        wen   = wa;
        wdata = ent_a;
        wdata.vx = va[0];
        wdata.vy = va[1];
        wdata.vz = va[2];
      end
      ST_WB_B: begin
        wen   = wb;
        waddr = AW'(rb);
        wdata = ent_b;
        wdata.vx = vb[0];
        wdata.vy = vb[1];
        wdata.vz = vb[2];
      end
      ST_DOT_M: begin
        mul_a = 33'(r[k]);
        mul_b = vsel ? 33'(u[k]) : 33'(nk);
      end
      ST_E_M: begin
        mul_a = 33'(ea);
        mul_b = 33'(eb);
      end
      ST_J_M: begin
        mul_a = 33'(e) + 33'(ONE_Q16);
        mul_b = -(33'(nspd));
      end
      ST_D_M: begin
        mul_a = dsrc;
        mul_b = vsel ? 33'(u[k]) : 33'(nk);
      end
      ST_APA_M: begin
        mul_a = 33'(d[k]);
        mul_b = 33'(ia);
      end
      ST_APB_M: begin
        mul_a = 33'(d[k]);
        mul_b = 33'(ib);
      end
      ST_T_M: begin
        mul_a = 33'(nspd);
        mul_b = 33'(nk);
      end
      ST_SQ_M: begin
        mul_a = 33'(t[k]);
        mul_b = 33'(t[k]);
      end
      ST_FR_M1: begin
        mul_a = 33'(fr_dyn ? ka : sa);
        mul_b = 33'(fr_dyn ? ka : sa);
      end
      ST_FR_M2: begin
        mul_a = 33'(fr_dyn ? kb : sb);
        mul_b = 33'(fr_dyn ? kb : sb);
      end
      ST_CMP_M: begin
        mul_a = 33'(j);
        mul_b = 33'(mus);
      end
      ST_JM_M: begin
        mul_a = 33'(j);
        mul_b = 33'(mud);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      body_mem[waddr] <= wdata;
    end
    rd_data <= body_mem[raddr];
    prod    <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          kind    <= kind_t'(s_tuser);
          ra      <= s_tdata[5:0];
          rb      <= s_tdata[11:6];
          ld.vx   <= s_tdata[43:12];
          ld.vy   <= s_tdata[75:44];
          ld.vz   <= s_tdata[107:76];
          ld.inv  <= s_tdata[131:108];
          ld.rest <= s_tdata[148:132];
          ld.sfr  <= s_tdata[164:149];
          ld.dfr  <= s_tdata[180:165];
          ld.mode <= s_tdata[182:181];
        end
      end
      ST_REDUCE: begin
        if (ra_big) begin
          ra <= ra - 6'(BODY_COUNT);
        end else if (rb_big) begin
          rb <= rb - 6'(BODY_COUNT);
        end
      end
      ST_GET_A: begin
        ent_a   <= rd_data;
        va[0]   <= rd_data.vx;
        va[1]   <= rd_data.vy;
        va[2]   <= rd_data.vz;
        outcome <= OUT_READ;
      end
      ST_GET_B: begin
        ent_b <= rd_data;
        vb[0] <= rd_data.vx;
        vb[1] <= rd_data.vy;
        vb[2] <= rd_data.vz;
      end
      ST_INIT: begin
        phase   <= PH_FIRST;
        fr_dyn  <= 1'b0;
        outcome <= OUT_BOTH_STATIC;
      end
      ST_REL: begin
        for (int i = 0; i < 3; i++) begin
          r[i] <= sat32(66'(db ? vb[i] : 32'sd0) - 66'(da ? va[i] : 32'sd0));
        end
        acc <= '0;
        k   <= 2'd0;
      end
      ST_DOT_A: begin
        acc <= acc + 50'(prod >>> 16);
        k   <= k_wrap;
      end
      ST_DOT_END: begin
        case (phase)
          PH_FIRST: begin
            nspd <= dot_val;
            if (dot_val >= 0) outcome <= OUT_SEPARATING;
          end
          PH_SECOND: begin
            nspd <= dot_val;
            sq   <= '0;
          end
          default: fvel <= dot_val;
        endcase
      end
      ST_E_A: e <= prod[33:16];
      ST_J_A: begin
        dv      <= prod[51:0];
        ds      <= 33'(msum);
        div_neg <= 1'b0;
        rem     <= '0;
        cnt     <= '0;
        div_ret <= ST_J_DONE;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, ds}) begin
          rem <= 33'(rem_sh - {1'b0, ds});
          dv  <= {dv[50:0], 1'b1};
        end else begin
          rem <= rem_sh[32:0];
          dv  <= {dv[50:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
      end
      ST_J_DONE: begin
        j    <= quot_s;
        dsrc <= 33'(quot_s);
      end
      ST_D_A: begin
        d[k] <= sat32(prod >>> 16);
        k    <= k_wrap;
      end
      ST_APA_A: begin
        if (wa) va[k] <= sat32(66'(va[k]) - (prod >>> 16));
      end
      ST_APB_A: begin
        if (wb) vb[k] <= sat32(66'(vb[k]) + (prod >>> 16));
        k <= k_wrap;
        if (k == 2'd2 && phase == PH_FIRST) phase <= PH_SECOND;
      end
      ST_T_A: t[k] <= sat32(66'(r[k]) - (prod >>> 16));
      ST_SQ_A: begin
        sq <= sq + prod[63:0];
        k  <= k_wrap;
        if (k == 2'd2) begin
          sv       <= sq + prod[63:0];
          sr       <= '0;
          sbit     <= 64'd1 << 62;
          cnt      <= '0;
          sqrt_ret <= ST_L_DONE;
        end
      end
      ST_SQRT: begin
        if (sv >= s_sum) begin
          sv <= sv - s_sum;
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
        cnt  <= cnt + 6'd1;
      end
      ST_L_DONE: begin
        len <= sr[32:0];
        if (sr <= 64'(TAN_MIN)) outcome <= OUT_IMPULSE;
      end
      ST_U_DIV: begin
        dv      <= {3'd0, tabs, 16'd0};
        ds      <= len;
        div_neg <= t[k][31];
        rem     <= '0;
        cnt     <= '0;
        div_ret <= ST_U_DONE;
      end
      ST_U_DONE: begin
        u[k] <= quot_s;
        k    <= k_wrap;
        if (k == 2'd2) begin
          phase <= PH_FRIC;
          acc   <= '0;
        end
      end
      ST_FR_A1: sq <= prod[63:0];
      ST_FR_A2: begin
        sv       <= sq + prod[63:0];
        sr       <= '0;
        sbit     <= 64'd1 << 62;
        cnt      <= '0;
        sqrt_ret <= fr_dyn ? ST_MUD_DONE : ST_MUS_DONE;
      end
      ST_MUS_DONE: mus <= sr[17:0];
      ST_F_DIV: begin
        dv      <= {3'd0, fabs, 16'd0};
        ds      <= 33'(msum);
        div_neg <= !fvel[31];
        rem     <= '0;
        cnt     <= '0;
        div_ret <= ST_F_DONE;
      end
      ST_F_DONE: f <= quot_s;
      ST_CMP_A: begin
        if (static_hit) begin
          outcome <= OUT_STATIC;
          dsrc    <= 33'(f);
        end else begin
          fr_dyn <= 1'b1;
        end
      end
      ST_MUD_DONE: mud <= sr[17:0];
      ST_JM_A: begin
        dsrc    <= -(33'(jm_val));
        outcome <= OUT_DYNAMIC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT_A || state == ST_EMIT_B) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_A && out_free) begin
      m_tdata <= {2'd0, va[2], va[1], va[0], ra};
      m_tuser <= outcome;
      m_tlast <= (kind == KIND_READ);
    end else if (state == ST_EMIT_B && out_free) begin
      m_tdata <= {2'd0, vb[2], vb[1], vb[0], rb};
      m_tuser <= outcome;
      m_tlast <= 1'b1;
    end
  end

  a_read_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == OUT_READ |-> m_tlast)
    else $error("read result without last");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> ds != 33'd0)
    else $error("division by zero");

  a_second_only_resolve: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT_B |-> kind == KIND_RESOLVE)
    else $error("second result for a non-resolve item");

  a_index_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_DISPATCH |-> !ra_big && !rb_big)
    else $error("body index not reduced");

endmodule
